// File: rtl/core/simple_glyph_outline_decoder_assert.svh
// Assertion macros shared by the glyph decoder checker.
`ifndef SIMPLE_GLYPH_OUTLINE_DECODER_ASSERT_SVH
`define SIMPLE_GLYPH_OUTLINE_DECODER_ASSERT_SVH
// Property that must hold at every clock edge outside reset.
`define SGOD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SGOD_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/core/sgod_pkg.sv
// Package with types and constants of the glyph decoder.
`default_nettype none
package sgod_pkg;
  localparam int MaxPoints   = 64;
  localparam int MaxContours = 64;
  localparam int PtW = $clog2(MaxPoints);
  localparam int CnW = $clog2(MaxContours);

  localparam logic [2:0] ST_POINT         = 3'd0;
  localparam logic [2:0] ST_COMPOSITE     = 3'd1;
  localparam logic [2:0] ST_NO_CONTOURS   = 3'd2;
  localparam logic [2:0] ST_CONTOURS_OVER = 3'd3;
  localparam logic [2:0] ST_INSTR_OVER    = 3'd4;
  localparam logic [2:0] ST_POINTS_BAD    = 3'd5;

  localparam logic [1:0] CFG_CONTOUR_LIMIT = 2'd0;
  localparam logic [1:0] CFG_POINT_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_INSTR_LIMIT   = 2'd2;

  localparam int F_ON = 0;
  localparam int F_XSHORT = 1;
  localparam int F_YSHORT = 2;
  localparam int F_REPEAT = 3;
  localparam int F_XSAME = 4;
  localparam int F_YSAME = 5;

  typedef enum logic [4:0] {
    PH_IDLE, PH_NC_LO, PH_BBOX, PH_END_HI, PH_END_LO, PH_INS_HI, PH_INS_LO,
    PH_INS_SKIP, PH_NPTS, PH_FLAG, PH_REPEAT, PH_COORD, PH_X, PH_X_LO,
    PH_Y, PH_Y_LO, PH_CE, PH_EMIT, PH_STATUS
  } phase_t;

  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        on_curve;
    logic        contour_end;
    logic        last_of_glyph;
    logic [2:0]  status;
  } result_t;
endpackage
`default_nettype wire

// File: rtl/core/sgod_store.sv
// Point store: flags and x coordinates in one synchronous memory.
`default_nettype none
module sgod_store (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [sgod_pkg::PtW-1:0] waddr,
  input  wire logic [21:0]              wdata,
  input  wire logic [sgod_pkg::PtW-1:0] raddr,
  output logic      [21:0]              rdata
);
  logic [21:0] mem [sgod_pkg::MaxPoints];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/sgod_ends.sv
// Contour end index memory.
`default_nettype none
module sgod_ends (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [sgod_pkg::CnW-1:0] waddr,
  input  wire logic [15:0]              wdata,
  input  wire logic [sgod_pkg::CnW-1:0] raddr,
  output logic      [15:0]              rdata
);
  logic [15:0] mem [sgod_pkg::MaxContours];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/simple_glyph_outline_decoder.sv
// Top level of the simple outline glyph decoder.
//
// Channel | Direction | Contents
// in_     | slave     | tdata[7:0] data_byte, tuser glyph_start
// out_    | master    | tdata x[15:0] y[31:16] on[32] ce[33]; tuser status[2:0]; tlast
// cfg_    | write     | index 0..2, data 16 bits
//
// After a repeat count byte each copied flag is written to the store in turn, and then
// the parser returns to the flag bytes, or starts the coordinates once all points are set.
// An X coordinate reads its flag, then takes its byte, its two bytes or a zero step;
// each coordinate pass starts in PH_COORD, and PH_NPTS checks the point count.
// A Y coordinate does the same, then walks past the contour end entries in PH_CE
// before its point is emitted in PH_EMIT.
// Reset is synchronous and active low; the memories are not cleared.
// A stalled output holds the parser and the input; glyph_start is taken only
// while the parser waits for a byte, so results already due are never dropped.
`default_nettype none
module simple_glyph_outline_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // glyph_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // point_x, point_y, on_curve, contour_end
  output logic [2:0]       out_tuser,  // status
  output logic             out_tlast,  // last_of_glyph
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int PtW = sgod_pkg::PtW;
  localparam int CnW = sgod_pkg::CnW;

  sgod_pkg::phase_t ph_r, ph_nxt;
  logic [6:0]  climit_r, plimit_r;
  logic [15:0] ilimit_r;
  logic [15:0] cnt_r, cnt_nxt;
  logic [6:0]  ncont_r, ncont_nxt;
  logic [6:0]  pidx_r, pidx_nxt, ptot_r, ptot_nxt, cptr_r, cptr_nxt;
  logic [7:0]  rep_r, rep_nxt, hold_r, hold_nxt;
  logic [15:0] run_r, run_nxt;
  logic        isy_r, isy_nxt;
  logic [5:0]  lastflag_r, lastflag_nxt;
  logic        ce_r, ce_nxt;
  logic        ovld_r, ovld_nxt;
  sgod_pkg::result_t ores_r, ores_nxt;

  logic        st_we, en_we;
  logic [PtW-1:0] st_waddr, st_raddr;
  logic [21:0] st_wdata, st_rdata;
  logic [CnW-1:0] en_waddr, en_raddr;
  logic [15:0] en_wdata, en_rdata;

  logic acc, busy_out;
  logic [5:0] fl;
  logic xy_short, xy_same, xy_wait;
  logic [15:0] word;
  logic [6:0]  clim, plim;
  logic [16:0] npts;

  sgod_store u_store (.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
                      .raddr(st_raddr), .rdata(st_rdata));
  sgod_ends u_ends (.clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
                    .raddr(en_raddr), .rdata(en_rdata));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      climit_r <= 7'd16;
      plimit_r <= 7'd64;
      ilimit_r <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgod_pkg::CFG_CONTOUR_LIMIT: climit_r <= cfg_data[6:0];
        sgod_pkg::CFG_POINT_LIMIT:   plimit_r <= cfg_data[6:0];
        sgod_pkg::CFG_INSTR_LIMIT:   ilimit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A coordinate phase waits for a byte only once its flag is read and it needs one.
  assign xy_short = isy_r ? fl[sgod_pkg::F_YSHORT] : fl[sgod_pkg::F_XSHORT];
  assign xy_same  = isy_r ? fl[sgod_pkg::F_YSAME] : fl[sgod_pkg::F_XSAME];
  assign xy_wait  = (ph_r == sgod_pkg::PH_X || ph_r == sgod_pkg::PH_Y) && ce_r &&
                    (xy_short || !xy_same);

  assign busy_out = ovld_r && !out_tready;
  assign in_tready = !busy_out && (ph_r == sgod_pkg::PH_IDLE ||
    ph_r == sgod_pkg::PH_NC_LO || ph_r == sgod_pkg::PH_BBOX ||
    ph_r == sgod_pkg::PH_END_HI || ph_r == sgod_pkg::PH_END_LO ||
    ph_r == sgod_pkg::PH_INS_HI || ph_r == sgod_pkg::PH_INS_LO ||
    ph_r == sgod_pkg::PH_INS_SKIP || ph_r == sgod_pkg::PH_FLAG ||
    (ph_r == sgod_pkg::PH_REPEAT && rep_r == 8'd0 && !ce_r) ||
    xy_wait || ph_r == sgod_pkg::PH_X_LO || ph_r == sgod_pkg::PH_Y_LO);
  assign acc = in_tvalid && in_tready;
  assign fl = st_rdata[21:16];
  assign word = {hold_r, in_tdata};
  assign clim = (climit_r < 7'(sgod_pkg::MaxContours)) ? climit_r : 7'(sgod_pkg::MaxContours);
  assign plim = (plimit_r < 7'(sgod_pkg::MaxPoints)) ? plimit_r : 7'(sgod_pkg::MaxPoints);
  assign npts = {1'b0, en_rdata} + 17'd1;

  // Next state: one byte or one memory step per cycle unless the output stalls.
  always_comb begin
    logic [15:0] delta;
    logic        done;
    ph_nxt = ph_r; cnt_nxt = cnt_r; ncont_nxt = ncont_r; pidx_nxt = pidx_r;
    ptot_nxt = ptot_r; cptr_nxt = cptr_r; rep_nxt = rep_r; hold_nxt = hold_r;
    run_nxt = run_r; isy_nxt = isy_r; lastflag_nxt = lastflag_r; ce_nxt = ce_r;
    ovld_nxt = busy_out; ores_nxt = ores_r;
    st_we = 1'b0; st_waddr = pidx_r[PtW-1:0]; st_wdata = {lastflag_r, run_r};
    st_raddr = pidx_r[PtW-1:0];
    en_we = 1'b0; en_waddr = cptr_r[CnW-1:0]; en_wdata = word;
    en_raddr = cptr_r[CnW-1:0];
    delta = 16'd0; done = 1'b0;
    if (acc && in_tuser) begin
      hold_nxt = in_tdata; cnt_nxt = '0; ncont_nxt = '0; pidx_nxt = '0;
      ptot_nxt = '0; run_nxt = '0; cptr_nxt = '0; ph_nxt = sgod_pkg::PH_NC_LO;
    end else if (!busy_out) begin
      unique case (ph_r)
        sgod_pkg::PH_NC_LO: if (acc) begin
          ph_nxt = sgod_pkg::PH_STATUS;
          if (word[15]) ores_nxt.status = sgod_pkg::ST_COMPOSITE;
          else if (word == 16'd0) ores_nxt.status = sgod_pkg::ST_NO_CONTOURS;
          else if (word > {9'd0, clim}) ores_nxt.status = sgod_pkg::ST_CONTOURS_OVER;
          else begin
            ncont_nxt = word[6:0]; cnt_nxt = 16'd8; ph_nxt = sgod_pkg::PH_BBOX;
          end
        end
        sgod_pkg::PH_BBOX: if (acc) begin
          cnt_nxt = cnt_r - 16'd1;
          if (cnt_r == 16'd1) begin
            cptr_nxt = '0; ph_nxt = sgod_pkg::PH_END_HI;
          end
        end
        sgod_pkg::PH_END_HI: if (acc) begin
          hold_nxt = in_tdata; ph_nxt = sgod_pkg::PH_END_LO;
        end
        sgod_pkg::PH_END_LO: if (acc) begin
          en_we = 1'b1;
          cptr_nxt = cptr_r + 7'd1;
          if (cptr_r + 7'd1 >= ncont_r) begin
            cptr_nxt = '0; ph_nxt = sgod_pkg::PH_INS_HI;
          end else ph_nxt = sgod_pkg::PH_END_HI;
        end
        sgod_pkg::PH_INS_HI: if (acc) begin
          hold_nxt = in_tdata; ph_nxt = sgod_pkg::PH_INS_LO;
          en_raddr = CnW'(ncont_r - 7'd1);
        end
        sgod_pkg::PH_INS_LO: begin
          en_raddr = CnW'(ncont_r - 7'd1);
          if (acc) begin
            if (word > ilimit_r) begin
              ores_nxt.status = sgod_pkg::ST_INSTR_OVER; ph_nxt = sgod_pkg::PH_STATUS;
            end else if (word == 16'd0) ph_nxt = sgod_pkg::PH_NPTS;
            else begin
              cnt_nxt = word; ph_nxt = sgod_pkg::PH_INS_SKIP;
            end
          end
        end
        sgod_pkg::PH_INS_SKIP: begin
          en_raddr = CnW'(ncont_r - 7'd1);
          if (acc) begin
            cnt_nxt = cnt_r - 16'd1;
            if (cnt_r == 16'd1) ph_nxt = sgod_pkg::PH_NPTS;
          end
        end
        sgod_pkg::PH_NPTS: begin
          if (npts > {10'd0, plim}) begin
            ores_nxt.status = sgod_pkg::ST_POINTS_BAD; ph_nxt = sgod_pkg::PH_STATUS;
          end else begin
            ptot_nxt = npts[6:0]; pidx_nxt = '0; ph_nxt = sgod_pkg::PH_FLAG;
          end
        end
        sgod_pkg::PH_FLAG: if (acc) begin
          st_we = 1'b1; st_wdata = {in_tdata[5:0], 16'd0};
          lastflag_nxt = in_tdata[5:0];
          pidx_nxt = pidx_r + 7'd1;
          if (in_tdata[sgod_pkg::F_REPEAT]) begin
            rep_nxt = 8'd0; ce_nxt = 1'b0; ph_nxt = sgod_pkg::PH_REPEAT;
          end else if (pidx_r + 7'd1 >= ptot_r) ph_nxt = sgod_pkg::PH_COORD;
        end
        sgod_pkg::PH_REPEAT: begin
          // ce_r marks that the count byte has been taken.
          if (!ce_r) begin
            if (acc) begin
              rep_nxt = in_tdata; ce_nxt = 1'b1;
            end
          end else if (rep_r != 8'd0 && pidx_r < ptot_r) begin
            st_we = 1'b1; st_wdata = {lastflag_r, 16'd0};
            pidx_nxt = pidx_r + 7'd1; rep_nxt = rep_r - 8'd1;
          end else begin
            ce_nxt = 1'b0; rep_nxt = 8'd0;
            ph_nxt = (pidx_r >= ptot_r) ? sgod_pkg::PH_COORD : sgod_pkg::PH_FLAG;
          end
        end
        sgod_pkg::PH_COORD: begin
          // Start a coordinate pass; memory read of point 0 issued here.
          pidx_nxt = '0; run_nxt = '0; cptr_nxt = '0; st_raddr = '0;
          ph_nxt = isy_r ? sgod_pkg::PH_Y : sgod_pkg::PH_X;
          ce_nxt = 1'b0;
        end
        sgod_pkg::PH_X, sgod_pkg::PH_Y: begin
          // ce_r set once the flag read for this point is valid.
          if (!ce_r) begin
            ce_nxt = 1'b1;
          end else if (!isy_r ? fl[sgod_pkg::F_XSHORT] : fl[sgod_pkg::F_YSHORT]) begin
            if (acc) begin
              delta = (isy_r ? fl[sgod_pkg::F_YSAME] : fl[sgod_pkg::F_XSAME]) ?
                      {8'd0, in_tdata} : 16'd0 - {8'd0, in_tdata};
              done = 1'b1;
            end
          end else if (isy_r ? fl[sgod_pkg::F_YSAME] : fl[sgod_pkg::F_XSAME]) begin
            done = 1'b1;
          end else if (acc) begin
            hold_nxt = in_tdata; ph_nxt = isy_r ? sgod_pkg::PH_Y_LO : sgod_pkg::PH_X_LO;
          end
        end
        sgod_pkg::PH_X_LO, sgod_pkg::PH_Y_LO: if (acc) begin
          delta = word; done = 1'b1;
        end
        sgod_pkg::PH_CE: begin
          // Walk end indices; en_rdata holds entry cptr_r.
          if (ce_r) begin
            ce_nxt = 1'b0;
          end else if (cptr_r < ncont_r && en_rdata < {9'd0, pidx_r}) begin
            cptr_nxt = cptr_r + 7'd1; en_raddr = CnW'(cptr_r + 7'd1); ce_nxt = 1'b1;
          end else begin
            ores_nxt.contour_end = (pidx_r + 7'd1 >= ptot_r) ||
              (cptr_r < ncont_r && en_rdata == {9'd0, pidx_r});
            if (cptr_r < ncont_r && en_rdata == {9'd0, pidx_r}) cptr_nxt = cptr_r + 7'd1;
            ph_nxt = sgod_pkg::PH_EMIT;
          end
        end
        sgod_pkg::PH_EMIT: begin
          ovld_nxt = 1'b1;
          ores_nxt.point_x = st_rdata[15:0]; ores_nxt.point_y = run_r;
          ores_nxt.on_curve = fl[sgod_pkg::F_ON];
          ores_nxt.last_of_glyph = (pidx_r + 7'd1 >= ptot_r);
          ores_nxt.status = sgod_pkg::ST_POINT;
          pidx_nxt = pidx_r + 7'd1; st_raddr = PtW'(pidx_r + 7'd1); ce_nxt = 1'b0;
          en_raddr = cptr_r[CnW-1:0];
          ph_nxt = (pidx_r + 7'd1 >= ptot_r) ? sgod_pkg::PH_IDLE : sgod_pkg::PH_Y;
        end
        sgod_pkg::PH_STATUS: begin
          ovld_nxt = 1'b1;
          ores_nxt.point_x = '0; ores_nxt.point_y = '0; ores_nxt.on_curve = 1'b0;
          ores_nxt.contour_end = 1'b0; ores_nxt.last_of_glyph = 1'b1;
          ph_nxt = sgod_pkg::PH_IDLE;
        end
        default: ;
      endcase
      // A coordinate is complete.
      if (done) begin
        run_nxt = run_r + delta;
        ce_nxt = 1'b0;
        if (!isy_r) begin
          st_we = 1'b1; st_wdata = {fl, run_r + delta};
          pidx_nxt = pidx_r + 7'd1; st_raddr = PtW'(pidx_r + 7'd1);
          ph_nxt = sgod_pkg::PH_X;
          if (pidx_r + 7'd1 >= ptot_r) begin
            isy_nxt = 1'b1; ph_nxt = sgod_pkg::PH_COORD;
          end
        end else begin
          ph_nxt = sgod_pkg::PH_CE; ce_nxt = 1'b1; en_raddr = cptr_r[CnW-1:0];
        end
      end
      if (ph_r == sgod_pkg::PH_INS_SKIP || ph_r == sgod_pkg::PH_INS_LO) isy_nxt = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= sgod_pkg::PH_IDLE; cnt_r <= '0; ncont_r <= '0; pidx_r <= '0;
      ptot_r <= '0; cptr_r <= '0; rep_r <= '0; hold_r <= '0; run_r <= '0;
      isy_r <= 1'b0; ce_r <= 1'b0; ovld_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; cnt_r <= cnt_nxt; ncont_r <= ncont_nxt; pidx_r <= pidx_nxt;
      ptot_r <= ptot_nxt; cptr_r <= cptr_nxt; rep_r <= rep_nxt; hold_r <= hold_nxt;
      run_r <= run_nxt; isy_r <= isy_nxt; ce_r <= ce_nxt; ovld_r <= ovld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    lastflag_r <= lastflag_nxt;
    ores_r <= ores_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = {6'd0, ores_r.contour_end, ores_r.on_curve,
                      ores_r.point_y, ores_r.point_x};
  assign out_tuser = ores_r.status;
  assign out_tlast = ores_r.last_of_glyph;
endmodule
`default_nettype wire

// File: rtl/core/sgod_checker.sv
// Port checker for the glyph decoder, bound to the top level.
`default_nettype none
`include "simple_glyph_outline_decoder_assert.svh"
module sgod_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);
  `SGOD_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output changed while stalled")
  `SGOD_ASSERT(a_status_last, clk, rst_n, (out_tvalid && out_tuser != sgod_pkg::ST_POINT) |-> out_tlast, "status result without last mark")
  `SGOD_ASSERT(a_status_zero, clk, rst_n, (out_tvalid && out_tuser != sgod_pkg::ST_POINT) |-> (out_tdata[33:0] == 34'd0), "status result with point data")
  `SGOD_ASSERT(a_last_ce, clk, rst_n, (out_tvalid && out_tlast && out_tuser == sgod_pkg::ST_POINT) |-> out_tdata[33], "last point not a contour end")
  `SGOD_ASSERT(a_code, clk, rst_n, out_tvalid |-> (out_tuser <= sgod_pkg::ST_POINTS_BAD), "status code out of range")
endmodule

bind simple_glyph_outline_decoder sgod_checker u_sgod_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);
`default_nettype wire

// File: verif/simple_glyph_outline_decoder_tb.sv
// Self-checking testbench for the simple outline glyph decoder.
`timescale 1ns / 100ps
module simple_glyph_outline_decoder_tb;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 300;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } glyph_byte_t;

  typedef enum int {
    G_IDLE, G_NC_LO, G_BBOX, G_END_HI, G_END_LO, G_INS_HI, G_INS_LO, G_INS_SKIP,
    G_FLAG, G_REPEAT, G_X, G_X_LO, G_Y, G_Y_LO
  } glyph_phase_t;

  typedef enum int {
    K_NORMAL, K_TRUNC, K_COMPOSITE, K_NO_CONT, K_CONT_OVER, K_INS_OVER, K_PTS_BAD, K_STRAY
  } glyph_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = sgod_pkg::CFG_CONTOUR_LIMIT;
  logic [15:0] cfg_data = 16'h0000;

  simple_glyph_outline_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  glyph_byte_t         pending_bytes[$];
  sgod_pkg::result_t   expected_points[$];
  int                  error_count = 0;
  int                  phase_bytes = 0;

  // Limits as the stimulus generator sees them.
  int gen_cl = 16, gen_pl = 64, gen_il = 65535;

  // Decoder state mirrored by the predictor.
  int             pm_cl = 16, pm_pl = 64, pm_il = 65535;
  glyph_phase_t   gph = G_IDLE;
  int             byte_cnt = 0, ncont = 0, pidx = 0, ptotal = 0, cptr = 0;
  logic [15:0]    run_coord = 16'h0000;
  logic [7:0]     hold_byte = 8'h00;
  logic [15:0]    end_mem [64];
  logic [5:0]     flag_mem [64];
  logic [15:0]    x_mem [64];

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic void push_point(input logic [15:0] x, input logic [15:0] y,
                                     input logic on, input logic ce, input logic last,
                                     input logic [2:0] st);
    sgod_pkg::result_t r;
    r.point_x = x; r.point_y = y; r.on_curve = on; r.contour_end = ce;
    r.last_of_glyph = last; r.status = st;
    expected_points.push_back(r);
  endfunction

  function automatic void glyph_status(input logic [2:0] st);
    push_point(16'h0, 16'h0, 1'b0, 1'b0, 1'b1, st);
    gph = G_IDLE;
  endfunction

  function automatic int coord_len(input bit is_x);
    logic [5:0] f;
    f = flag_mem[pidx & 63];
    if (is_x ? f[sgod_pkg::F_XSHORT] : f[sgod_pkg::F_YSHORT]) return 1;
    return (is_x ? f[sgod_pkg::F_XSAME] : f[sgod_pkg::F_YSAME]) ? 0 : 2;
  endfunction

  function automatic void finish_coord(input logic [15:0] delta);
    int  i;
    bit  last;
    bit  ce;
    i = pidx & 63;
    run_coord = run_coord + delta;
    if (gph == G_X) begin
      x_mem[i] = run_coord;
      pidx++;
      if (pidx >= ptotal) begin
        pidx = 0; run_coord = 16'h0; gph = G_Y;
      end
      return;
    end
    last = (pidx + 1 >= ptotal);
    ce = 0;
    // Skip end indices behind the current point, then test for a match.
    while (cptr < ncont && int'(end_mem[cptr & 63]) < pidx) cptr++;
    if (cptr < ncont && int'(end_mem[cptr & 63]) == pidx) begin
      ce = 1; cptr++;
    end
    push_point(x_mem[i], run_coord, flag_mem[i][sgod_pkg::F_ON], ce || last, last,
               sgod_pkg::ST_POINT);
    pidx++;
    if (last) gph = G_IDLE;
  endfunction

  function automatic void settle_coords();
    while ((gph == G_X || gph == G_Y) && coord_len(gph == G_X) == 0) finish_coord(16'h0);
  endfunction

  function automatic void begin_flags();
    int n;
    int lim;
    n = int'(end_mem[(ncont - 1) & 63]) + 1;
    lim = pm_pl < 64 ? pm_pl : 64;
    if (n > lim) begin
      glyph_status(sgod_pkg::ST_POINTS_BAD);
      return;
    end
    ptotal = n; pidx = 0; gph = G_FLAG;
  endfunction

  function automatic void coord_byte(input logic [7:0] b, input bit is_x);
    logic [5:0] f;
    bit         same;
    f = flag_mem[pidx & 63];
    same = is_x ? f[sgod_pkg::F_XSAME] : f[sgod_pkg::F_YSAME];
    if (coord_len(is_x) == 1) begin
      finish_coord(same ? {8'h00, b} : 16'h0000 - {8'h00, b});
      settle_coords();
    end else begin
      hold_byte = b;
      gph = is_x ? G_X_LO : G_Y_LO;
    end
  endfunction

  // Advances the predictor by one accepted byte.
  function automatic void decode_byte(input logic [7:0] b, input logic start);
    logic [15:0] v;
    int          lim;
    int          r;
    if (start) begin
      hold_byte = b; byte_cnt = 0; ncont = 0; pidx = 0; ptotal = 0;
      run_coord = 16'h0; cptr = 0; gph = G_NC_LO;
      return;
    end
    v = {hold_byte, b};
    case (gph)
      G_NC_LO: begin
        lim = pm_cl < 64 ? pm_cl : 64;
        if (v[15]) glyph_status(sgod_pkg::ST_COMPOSITE);
        else if (v == 0) glyph_status(sgod_pkg::ST_NO_CONTOURS);
        else if (int'(v) > lim) glyph_status(sgod_pkg::ST_CONTOURS_OVER);
        else begin
          ncont = int'(v); byte_cnt = 8; gph = G_BBOX;
        end
      end
      G_BBOX: begin
        byte_cnt--;
        if (byte_cnt == 0) begin
          cptr = 0; gph = G_END_HI;
        end
      end
      G_END_HI: begin
        hold_byte = b; gph = G_END_LO;
      end
      G_END_LO: begin
        end_mem[cptr & 63] = v;
        cptr++;
        if (cptr >= ncont) begin
          cptr = 0; gph = G_INS_HI;
        end else gph = G_END_HI;
      end
      G_INS_HI: begin
        hold_byte = b; gph = G_INS_LO;
      end
      G_INS_LO: begin
        if (int'(v) > pm_il) glyph_status(sgod_pkg::ST_INSTR_OVER);
        else if (v == 0) begin_flags();
        else begin
          byte_cnt = int'(v); gph = G_INS_SKIP;
        end
      end
      G_INS_SKIP: begin
        byte_cnt--;
        if (byte_cnt == 0) begin_flags();
      end
      G_FLAG: begin
        flag_mem[pidx & 63] = b[5:0];
        pidx++;
        if (b[sgod_pkg::F_REPEAT]) gph = G_REPEAT;
        else if (pidx >= ptotal) begin
          pidx = 0; run_coord = 16'h0; cptr = 0; gph = G_X; settle_coords();
        end
      end
      G_REPEAT: begin
        r = int'(b);
        while (r > 0 && pidx < ptotal) begin
          flag_mem[pidx & 63] = flag_mem[(pidx - 1) & 63];
          pidx++; r--;
        end
        if (pidx >= ptotal) begin
          pidx = 0; run_coord = 16'h0; cptr = 0; gph = G_X; settle_coords();
        end else gph = G_FLAG;
      end
      G_X: coord_byte(b, 1);
      G_Y: coord_byte(b, 0);
      G_X_LO, G_Y_LO: begin
        gph = (gph == G_X_LO) ? G_X : G_Y;
        finish_coord(v);
        settle_coords();
      end
      default: ;
    endcase
  endfunction

  // Sender: bursts of transactions separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    logic        next_valid;
    glyph_byte_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tuser);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() > 0) begin
          item = pending_bytes.pop_front();
          in_tdata <= item.data;
          in_tuser <= item.start;
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // Receiver: alternating ready and stall runs of random length.
  bit rd_on = 1'b0;
  int rd_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rd_left == 0) begin
        rd_on = !rd_on;
        if (rd_on) rd_left = $urandom_range(1, 30);
        else rd_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24)
                                                   : $urandom_range(1, 3);
      end else rd_left--;
      out_tready <= rd_on;
    end
  end

  // Monitor: compare every result transaction with the oldest expected point.
  always @(posedge clk) begin
    sgod_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        report($sformatf("unexpected result %h status %0d last %b", out_tdata, out_tuser,
                         out_tlast));
      end else begin
        want = expected_points.pop_front();
        if (out_tdata[15:0] !== want.point_x)
          report($sformatf("point_x %h, expected %h", out_tdata[15:0], want.point_x));
        if (out_tdata[31:16] !== want.point_y)
          report($sformatf("point_y %h, expected %h", out_tdata[31:16], want.point_y));
        if (out_tdata[32] !== want.on_curve)
          report($sformatf("on_curve %b, expected %b", out_tdata[32], want.on_curve));
        if (out_tdata[33] !== want.contour_end)
          report($sformatf("contour_end %b, expected %b", out_tdata[33], want.contour_end));
        if (out_tlast !== want.last_of_glyph)
          report($sformatf("last_of_glyph %b, expected %b", out_tlast, want.last_of_glyph));
        if (out_tuser !== want.status)
          report($sformatf("status %0d, expected %0d", out_tuser, want.status));
      end
    end
  end

  // Watchdog on cycles without any transaction.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("[simple_glyph_outline_decoder] ERROR");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b, input logic s);
    glyph_byte_t item;
    item.data = b; item.start = s;
    pending_bytes.push_back(item);
    phase_bytes++;
  endtask

  // Builds one glyph of the given kind and queues its bytes.
  task automatic queue_glyph(input glyph_kind_t kind_in);
    glyph_kind_t kind;
    logic [7:0]  bq[$];
    logic [5:0]  fl [64];
    logic [7:0]  f;
    logic [15:0] v;
    int          cmax, pmax, nc, np, il, i, r, k, cut;
    kind = kind_in;
    cmax = gen_cl < 64 ? gen_cl : 64;
    pmax = gen_pl < 64 ? gen_pl : 64;
    if (kind == K_INS_OVER && gen_il == 65535) kind = K_NORMAL;
    if (cmax == 0 && kind inside {K_NORMAL, K_TRUNC, K_INS_OVER, K_PTS_BAD})
      kind = K_CONT_OVER;
    case (kind)
      K_STRAY: begin
        r = $urandom_range(1, 3);
        for (k = 0; k < r; k++) put(8'($urandom_range(0, 255)), 1'b0);
        return;
      end
      K_COMPOSITE: begin
        bq.push_back(8'($urandom_range(128, 255))); bq.push_back(8'($urandom_range(0, 255)));
      end
      K_NO_CONT: begin
        bq.push_back(8'h00); bq.push_back(8'h00);
      end
      K_CONT_OVER: begin
        v = ($urandom_range(0, 3) == 0) ? 16'h7FFF : 16'(cmax + $urandom_range(1, 3));
        bq.push_back(v[15:8]); bq.push_back(v[7:0]);
      end
      default: begin
        nc = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cmax)
                                         : $urandom_range(1, cmax < 4 ? cmax : 4);
        np = ($urandom_range(0, 9) == 0) ? $urandom_range(1, pmax)
                                         : $urandom_range(1, pmax < 6 ? pmax : 6);
        bq.push_back(8'h00); bq.push_back(8'(nc));
        for (k = 0; k < 8; k++) bq.push_back(8'($urandom_range(0, 255)));
        // End indices: random order and repeats before the final one.
        for (k = 0; k < nc; k++) begin
          v = (k == nc - 1) ? 16'(np - 1) : 16'($urandom_range(0, np - 1));
          if (kind == K_PTS_BAD && k == nc - 1)
            v = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'(pmax + $urandom_range(0, 20));
          bq.push_back(v[15:8]); bq.push_back(v[7:0]);
        end
        if (kind == K_INS_OVER)
          il = ($urandom_range(0, 2) == 0) ? 65535
               : $urandom_range(gen_il + 1, gen_il + 50 > 65535 ? 65535 : gen_il + 50);
        else il = $urandom_range(0, gen_il < 3 ? gen_il : 3);
        bq.push_back(8'(il >> 8)); bq.push_back(8'(il));
        if (kind != K_INS_OVER) begin
          for (k = 0; k < il; k++) bq.push_back(8'($urandom_range(0, 255)));
          if (kind != K_PTS_BAD) begin
            // Flags with run-length repeats, expanded alongside.
            i = 0;
            while (i < np) begin
              f = 8'($urandom_range(0, 255));
              if ($urandom_range(0, 2) != 0) f[sgod_pkg::F_REPEAT] = 1'b0;
              bq.push_back(f);
              fl[i] = f[5:0];
              i++;
              if (f[sgod_pkg::F_REPEAT]) begin
                r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
                bq.push_back(8'(r));
                while (r > 0 && i < np) begin
                  fl[i] = fl[i - 1]; i++; r--;
                end
              end
            end
            // X coordinates first, then Y.
            for (k = 0; k < 2; k++) begin
              for (i = 0; i < np; i++) begin
                if (k == 0 ? fl[i][sgod_pkg::F_XSHORT] : fl[i][sgod_pkg::F_YSHORT])
                  bq.push_back(8'($urandom_range(0, 255)));
                else if (!(k == 0 ? fl[i][sgod_pkg::F_XSAME] : fl[i][sgod_pkg::F_YSAME])) begin
                  bq.push_back(8'($urandom_range(0, 255)));
                  bq.push_back(8'($urandom_range(0, 255)));
                end
              end
            end
          end
        end
      end
    endcase
    cut = bq.size();
    if (kind == K_TRUNC && cut > 1) cut = $urandom_range(1, cut - 1);
    for (k = 0; k < cut; k++) put(bq[k], k == 0);
  endtask

  task automatic random_glyphs(input int budget);
    int pick;
    phase_bytes = 0;
    while (phase_bytes < budget) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) queue_glyph(K_NORMAL);
      else if (pick < 14) queue_glyph(K_TRUNC);
      else queue_glyph(glyph_kind_t'(pick - 12));
    end
  endtask

  task automatic wait_quiet();
    while (pending_bytes.size() != 0 || in_tvalid || expected_points.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    case (idx)
      sgod_pkg::CFG_CONTOUR_LIMIT: begin gen_cl = val; pm_cl = val & 8'h7F; end
      sgod_pkg::CFG_POINT_LIMIT:   begin gen_pl = val; pm_pl = val & 8'h7F; end
      default:                     begin gen_il = val; pm_il = val & 16'hFFFF; end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  int set_cl [6] = '{64, 0, 5, 64, 16, 3};
  int set_pl [6] = '{64, 1, 1, 64, 8, 64};
  int set_il [6] = '{65535, 0, 3, 0, 65535, 20};

  initial begin
    int s;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed glyphs under the reset limits.
    queue_glyph(K_COMPOSITE);
    queue_glyph(K_NO_CONT);
    queue_glyph(K_CONT_OVER);
    queue_glyph(K_STRAY);
    // One point whose both coordinates take no byte.
    put(8'h00, 1'b1); put(8'h01, 1'b0);
    for (s = 0; s < 8; s++) put(8'h00, 1'b0);
    put(8'h00, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
    put(8'h31, 1'b0);
    queue_glyph(K_PTS_BAD);
    queue_glyph(K_TRUNC);
    random_glyphs(30);

    for (s = 0; s < 6; s++) begin
      wait_quiet();
      write_reg(sgod_pkg::CFG_CONTOUR_LIMIT, set_cl[s]);
      write_reg(sgod_pkg::CFG_POINT_LIMIT, set_pl[s]);
      write_reg(sgod_pkg::CFG_INSTR_LIMIT, set_il[s]);
      random_glyphs(50);
    end

    wait_quiet();
    if (expected_points.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_points.size()));
    if (error_count == 0) begin
      $display("[simple_glyph_outline_decoder] OK");
    end else begin
      $display("[simple_glyph_outline_decoder] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sgod_pkg.sv
rtl/core/sgod_store.sv
rtl/core/sgod_ends.sv
rtl/core/simple_glyph_outline_decoder.sv
rtl/core/sgod_checker.sv
verif/simple_glyph_outline_decoder_tb.sv
